// ----- design/rle_pkg.sv -----
// Shared types, codes and constants of the Raft leader election unit.
package rle_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int TERM_W        = 32;
    localparam int LOG_W         = 32;
    localparam int TAG_W         = 16;
    localparam int ID_W          = 4;
    localparam int SIZE_W        = 5;
    localparam int VOTE_W        = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [VOTE_W-1:0] NONE_ID   = 5'd31;
    localparam logic [VOTE_W-1:0] VOTES_MAX = 5'd31;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_VREQ  = 2'd1,
        OP_VRESP = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_REPLY   = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_LEADER  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID  = 2'd0,
        REG_CLUSTER  = 2'd1,
        REG_LAST_IDX = 2'd2,
        REG_LAST_TRM = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]   node_id;
        logic [SIZE_W-1:0] cluster_size;
        logic [LOG_W-1:0]  own_last_index;
        logic [TERM_W-1:0] own_last_term;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   peer_id;
        logic [TERM_W-1:0] msg_term;
        logic [LOG_W-1:0]  cand_last_index;
        logic [TERM_W-1:0] cand_last_term;
        logic              granted_in;
        logic [TAG_W-1:0]  request_tag;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   dest;
        logic [TERM_W-1:0] out_term;
        logic              granted_out;
        logic [LOG_W-1:0]  out_last_index;
        logic [TERM_W-1:0] out_last_term;
        logic [TAG_W-1:0]  tag_out;
        logic [1:0]        role_now;
        logic              last;
    } result_t;

endpackage

// ----- design/rle_core.sv -----
// Election state registers and the per-item decision logic.
module rle_core
    import rle_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int PW        = $clog2(MAX_NODES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  item_t         item,
    input  cfg_t          cfg,
    input  logic [PW-1:0] n_eff,
    input  logic          has_peers,
    output logic          res_valid,
    output result_t       res,
    output logic          burst_start,
    output logic [TERM_W-1:0] term
);

    localparam int CW = (PW > VOTE_W) ? PW : VOTE_W;

    role_t             role_reg, role_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [VOTE_W-1:0] vote_reg, vote_next;
    logic [VOTE_W-1:0] votes_reg, votes_next;
    logic [VOTE_W-1:0] leader_reg, leader_next;

    logic              up_to_date;
    logic [PW-1:0]     half;

    assign up_to_date = (item.cand_last_term != cfg.own_last_term) ?
                        (item.cand_last_term > cfg.own_last_term) :
                        (item.cand_last_index >= cfg.own_last_index);
    assign half = n_eff >> 1;
    assign term = term_reg;

    always_comb begin
        logic [VOTE_W-1:0] vote_v;
        logic [VOTE_W-1:0] votes_inc;
        logic              grant;
        role_next   = role_reg;
        term_next   = term_reg;
        vote_next   = vote_reg;
        votes_next  = votes_reg;
        leader_next = leader_reg;
        res_valid   = 1'b0;
        res         = '0;
        burst_start = 1'b0;
        vote_v      = vote_reg;
        votes_inc   = (votes_reg == VOTES_MAX) ? votes_reg : votes_reg + 5'd1;
        grant       = 1'b0;
        if (accept) begin
            case (op_t'(item.op))
                OP_TICK: begin
                    if (role_reg != ROLE_LEADER) begin
                        role_next   = ROLE_CANDIDATE;
                        term_next   = term_reg + 32'd1;
                        vote_next   = {1'b0, cfg.node_id};
                        votes_next  = 5'd1;
                        burst_start = has_peers;
                    end
                end
                OP_VREQ: begin
                    if (item.msg_term >= term_reg) begin
                        if (item.msg_term > term_reg) begin
                            role_next   = ROLE_FOLLOWER;
                            term_next   = item.msg_term;
                            leader_next = NONE_ID;
                            vote_v      = NONE_ID;
                        end
                        if ((vote_v == NONE_ID || vote_v == {1'b0, item.peer_id}) &&
                            up_to_date) begin
                            vote_v = {1'b0, item.peer_id};
                            grant  = 1'b1;
                        end
                    end
                    vote_next       = vote_v;
                    res_valid       = 1'b1;
                    res.kind        = KIND_REPLY;
                    res.out_term    = term_next;
                    res.granted_out = grant;
                    res.tag_out     = item.request_tag;
                    res.role_now    = role_next;
                    res.last        = 1'b1;
                end
                OP_VRESP: begin
                    if (role_reg == ROLE_CANDIDATE) begin
                        if (item.msg_term > term_reg) begin
                            role_next   = ROLE_FOLLOWER;
                            term_next   = item.msg_term;
                            leader_next = NONE_ID;
                            vote_next   = NONE_ID;
                        end else if (item.msg_term == term_reg && item.granted_in) begin
                            if (CW'(votes_inc) > CW'(half)) begin
                                role_next    = ROLE_LEADER;
                                leader_next  = {1'b0, cfg.node_id};
                                votes_next   = '0;
                                vote_next    = NONE_ID;
                                res_valid    = 1'b1;
                                res.kind     = KIND_LEADER;
                                res.out_term = term_reg;
                                res.role_now = ROLE_LEADER;
                                res.last     = 1'b1;
                            end else begin
                                votes_next = votes_inc;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_reg   <= ROLE_FOLLOWER;
            term_reg   <= '0;
            vote_reg   <= NONE_ID;
            votes_reg  <= '0;
            leader_reg <= NONE_ID;
        end else begin
            role_reg   <= role_next;
            term_reg   <= term_next;
            vote_reg   <= vote_next;
            votes_reg  <= votes_next;
            leader_reg <= leader_next;
        end
    end

`ifndef ASSERT_OFF
    // a leader never carries a vote count
    a_leader_votes: assert property (@(posedge aclk) disable iff (!aresetn)
        role_reg == ROLE_LEADER |-> votes_reg == '0)
        else $error("leader with nonzero vote count");
    // a win notice comes only from the result that set the known leader
    a_win_leader: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_LEADER |=> leader_reg != NONE_ID)
        else $error("won election without a known leader");
`endif

endmodule

// ----- design/rle_req_gen.sv -----
// Sequencer that emits one vote request per peer after an election starts.
module rle_req_gen
    import rle_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int PW        = $clog2(MAX_NODES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              advance,
    input  cfg_t              cfg,
    input  logic [PW-1:0]     k_cnt,
    input  logic [TERM_W-1:0] term,
    output logic              busy,
    output result_t           req
);

    localparam int CW = (PW > VOTE_W) ? PW : VOTE_W;

    logic          active_reg, active_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] cnt_reg, cnt_next;

    logic [PW-1:0] dest_p;
    logic [CW-1:0] dest_w;
    logic [PW-1:0] cnt_inc;
    logic          is_last;

    // own id is skipped on the fly, so every cycle with advance high carries a request
    assign dest_p  = (CW'(p_reg) == CW'(cfg.node_id)) ? p_reg + PW'(1) : p_reg;
    assign dest_w  = CW'(dest_p);
    assign cnt_inc = cnt_reg + PW'(1);
    assign is_last = (cnt_inc == k_cnt);
    assign busy    = active_reg;

    always_comb begin
        req                = '0;
        req.kind           = KIND_REQUEST;
        req.dest           = dest_w[ID_W-1:0];
        req.out_term       = term;
        req.out_last_index = cfg.own_last_index;
        req.out_last_term  = cfg.own_last_term;
        req.role_now       = ROLE_CANDIDATE;
        req.last           = is_last;
    end

    always_comb begin
        active_next = active_reg;
        p_next      = p_reg;
        cnt_next    = cnt_reg;
        if (start) begin
            active_next = 1'b1;
            p_next      = '0;
            cnt_next    = '0;
        end else if (active_reg && advance) begin
            p_next   = dest_p + PW'(1);
            cnt_next = cnt_inc;
            if (is_last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            p_reg      <= '0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            p_reg      <= p_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    // the run never passes its request count
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> cnt_reg < k_cnt)
        else $error("vote request run overran its count");
`endif

endmodule

// ----- design/raft_leader_election_unit.sv -----
// Top level of the Raft leader election unit: config, output register, glue.
// A vote request, or a vote response that wins the election, shows its result on m_* in the next cycle.
// Throughput: one item per cycle while the output register drains outside a run (stateful core loop).
// An election tick starts a run of K vote requests (K = peers, at most MAX_NODES-1); the first
// is registered once the run starts, then one per cycle while m_* is not stalled; s_ready is low for the run.
// Reset (aresetn, synchronous, active low) restores follower role, term 0, no vote, defaults.
module raft_leader_election_unit
    import rle_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [ID_W-1:0]       s_peer_id,
    input  logic [TERM_W-1:0]     s_msg_term,
    input  logic [LOG_W-1:0]      s_cand_last_index,
    input  logic [TERM_W-1:0]     s_cand_last_term,
    input  logic                  s_granted_in,
    input  logic [TAG_W-1:0]      s_request_tag,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [ID_W-1:0]       m_dest,
    output logic [TERM_W-1:0]     m_out_term,
    output logic                  m_granted_out,
    output logic [LOG_W-1:0]      m_out_last_index,
    output logic [TERM_W-1:0]     m_out_last_term,
    output logic [TAG_W-1:0]      m_tag_out,
    output logic [1:0]            m_role_now,
    output logic                  m_last
);

    localparam int PW = $clog2(MAX_NODES + 1);
    localparam int CW = (PW > SIZE_W) ? PW : SIZE_W;

    cfg_t    cfg_reg;
    item_t   item;
    result_t res, req, out_reg;
    logic    out_valid_reg;

    logic              slot_free, accept, res_valid, burst_start, busy;
    logic [TERM_W-1:0] term;
    logic [PW-1:0]     n_eff, k_raw, k_cnt;
    logic              node_in;

    // config registers; the user must write them only while the unit is idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_id        <= '0;
            cfg_reg.cluster_size   <= 5'd3;
            cfg_reg.own_last_index <= '0;
            cfg_reg.own_last_term  <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_NODE_ID:  cfg_reg.node_id        <= cfg_wdata[ID_W-1:0];
                REG_CLUSTER:  cfg_reg.cluster_size   <= cfg_wdata[SIZE_W-1:0];
                REG_LAST_IDX: cfg_reg.own_last_index <= cfg_wdata[LOG_W-1:0];
                REG_LAST_TRM: cfg_reg.own_last_term  <= cfg_wdata[TERM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective cluster size: zero counts as one, clipped to MAX_NODES
    always_comb begin
        if (cfg_reg.cluster_size == '0) begin
            n_eff = PW'(1);
        end else if (CW'(cfg_reg.cluster_size) > CW'(MAX_NODES)) begin
            n_eff = PW'(MAX_NODES);
        end else begin
            n_eff = PW'(cfg_reg.cluster_size);
        end
    end

    // number of vote requests per election
    assign node_in = CW'(cfg_reg.node_id) < CW'(n_eff);
    assign k_raw   = n_eff - PW'(node_in);
    assign k_cnt   = (CW'(k_raw) > CW'(MAX_NODES - 1)) ? PW'(MAX_NODES - 1) : k_raw;

    assign item.op              = s_op;
    assign item.peer_id         = s_peer_id;
    assign item.msg_term        = s_msg_term;
    assign item.cand_last_index = s_cand_last_index;
    assign item.cand_last_term  = s_cand_last_term;
    assign item.granted_in      = s_granted_in;
    assign item.request_tag     = s_request_tag;

    // output register frees when empty or when its transfer completes
    assign slot_free = !out_valid_reg || m_ready;
    assign s_ready   = slot_free && !busy;
    assign accept    = s_valid && s_ready;

    rle_core #(
        .MAX_NODES (MAX_NODES),
        .PW        (PW)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (item),
        .cfg         (cfg_reg),
        .n_eff       (n_eff),
        .has_peers   (k_cnt != '0),
        .res_valid   (res_valid),
        .res         (res),
        .burst_start (burst_start),
        .term        (term)
    );

    rle_req_gen #(
        .MAX_NODES (MAX_NODES),
        .PW        (PW)
    ) u_req_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (burst_start),
        .advance (slot_free),
        .cfg     (cfg_reg),
        .k_cnt   (k_cnt),
        .term    (term),
        .busy    (busy),
        .req     (req)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (slot_free) begin
            out_valid_reg <= (accept && res_valid) || busy;
        end
    end

    // payload: core result and request run never compete (s_ready is low in a run)
    always_ff @(posedge aclk) begin
        if (slot_free) begin
            if (busy) begin
                out_reg <= req;
            end else if (accept && res_valid) begin
                out_reg <= res;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_dest           = out_reg.dest;
    assign m_out_term       = out_reg.out_term;
    assign m_granted_out    = out_reg.granted_out;
    assign m_out_last_index = out_reg.out_last_index;
    assign m_out_last_term  = out_reg.out_last_term;
    assign m_tag_out        = out_reg.tag_out;
    assign m_role_now       = out_reg.role_now;
    assign m_last           = out_reg.last;

`ifndef ASSERT_OFF
    // no input transfer while a request run is going out
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready)
        else $error("input taken during vote request run");
    // a run starts only from a tick that left the output slot usable
    a_start_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_start |-> accept && s_op == OP_TICK && !res_valid)
        else $error("request run started without a tick transfer");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for raft_leader_election_unit: election predictor plus random traffic.
import rle_pkg::*;

// Tracks the node's election state and holds the results each accepted item should produce.
class election_scoreboard;
    // register copy
    logic [ID_W-1:0]   node_id;
    logic [SIZE_W-1:0] cluster_size;
    logic [LOG_W-1:0]  own_last_index;
    logic [TERM_W-1:0] own_last_term;
    // election state
    role_t             role;
    logic [TERM_W-1:0] term;
    logic [VOTE_W-1:0] vote_rec;
    logic [VOTE_W-1:0] votes;
    logic [VOTE_W-1:0] ldr_known;
    result_t           expected_q[$];
    int unsigned       errors, items, results, requests, replies, notices;

    function new();
        node_id        = '0;
        cluster_size   = 5'd3;
        own_last_index = '0;
        own_last_term  = '0;
        role           = ROLE_FOLLOWER;
        term           = '0;
        vote_rec       = NONE_ID;
        votes          = '0;
        ldr_known      = NONE_ID;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NODE_ID:  node_id        = data[ID_W-1:0];
            REG_CLUSTER:  cluster_size   = data[SIZE_W-1:0];
            REG_LAST_IDX: own_last_index = data[LOG_W-1:0];
            REG_LAST_TRM: own_last_term  = data[TERM_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // cluster size as used for the peer list and the majority
    function int unsigned active_nodes();
        if (cluster_size == 0) return 1;
        if (cluster_size > MAX_NODES_DEF) return MAX_NODES_DEF;
        return cluster_size;
    endfunction

    function void push(kind_t kind, logic [ID_W-1:0] dest, logic granted,
                       logic [LOG_W-1:0] li, logic [TERM_W-1:0] lt, logic [TAG_W-1:0] tag);
        result_t r;
        r.kind           = kind;
        r.dest           = dest;
        r.out_term       = term;
        r.granted_out    = granted;
        r.out_last_index = li;
        r.out_last_term  = lt;
        r.tag_out        = tag;
        r.role_now       = role;
        r.last           = 1'b0;
        expected_q.push_back(r);
    endfunction

    function void leave_term(logic [TERM_W-1:0] t);
        role      = ROLE_FOLLOWER;
        term      = t;
        ldr_known = NONE_ID;
        vote_rec  = NONE_ID;
    endfunction

    function void note_input(item_t it);
        int unsigned before_n, sent, n;
        logic        grant, log_ok;
        items++;
        before_n = expected_q.size();
        case (op_t'(it.op))
            OP_TICK: if (role != ROLE_LEADER) begin
                role      = ROLE_CANDIDATE;
                term      = term + 1;
                vote_rec  = {1'b0, node_id};
                votes     = 5'd1;
                n         = active_nodes();
                sent      = 0;
                // node id may lie outside the cluster; the request count is capped anyway
                for (int unsigned p = 0; p < n && sent < MAX_NODES_DEF - 1; p++) begin
                    if (p != node_id) begin
                        push(KIND_REQUEST, ID_W'(p), 1'b0, own_last_index, own_last_term, '0);
                        sent++;
                    end
                end
            end
            OP_VREQ: begin
                grant = 1'b0;
                if (it.msg_term >= term) begin
                    if (it.msg_term > term) leave_term(it.msg_term);
                    if (it.cand_last_term != own_last_term)
                        log_ok = it.cand_last_term > own_last_term;
                    else
                        log_ok = it.cand_last_index >= own_last_index;
                    if ((vote_rec == NONE_ID || vote_rec == {1'b0, it.peer_id}) && log_ok) begin
                        vote_rec = {1'b0, it.peer_id};
                        grant    = 1'b1;
                    end
                end
                push(KIND_REPLY, '0, grant, '0, '0, it.request_tag);
            end
            OP_VRESP: if (role == ROLE_CANDIDATE) begin
                // sender is not checked, so any granted response in our term counts
                if (it.msg_term > term) begin
                    leave_term(it.msg_term);
                end else if (it.msg_term == term && it.granted_in) begin
                    if (votes < VOTES_MAX) votes++;
                    if (votes > active_nodes() / 2) begin
                        role      = ROLE_LEADER;
                        ldr_known = {1'b0, node_id};
                        votes     = '0;
                        vote_rec  = NONE_ID;
                        push(KIND_LEADER, '0, 1'b0, '0, '0, '0);
                    end
                end
            end
            default: ;
        endcase
        if (expected_q.size() > before_n) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function string show(result_t r);
        return $sformatf("kind=%0d dest=%0d term=%h gr=%0b li=%h lt=%h tag=%h role=%0d last=%0b",
                         r.kind, r.dest, r.out_term, r.granted_out, r.out_last_index,
                         r.out_last_term, r.tag_out, r.role_now, r.last);
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_q.size() == 0) begin
            flag($sformatf("result with nothing outstanding: %s", show(got)));
            return;
        end
        want = expected_q.pop_front();
        results++;
        case (kind_t'(want.kind))
            KIND_REQUEST: requests++;
            KIND_REPLY:   replies++;
            default:      notices++;
        endcase
        if (got !== want)
            flag($sformatf("result %0d\n  expected %s\n  actual   %s",
                           results, show(want), show(got)));
    endfunction
endclass

module testbench;

    localparam int IDLE_LIMIT = 2000;  // cycles without any transfer before giving up
    localparam int SETTLE     = 20;    // quiet cycles after the last result of a phase

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata         = '0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op              = '0;
    logic [ID_W-1:0]       s_peer_id         = '0;
    logic [TERM_W-1:0]     s_msg_term        = '0;
    logic [LOG_W-1:0]      s_cand_last_index = '0;
    logic [TERM_W-1:0]     s_cand_last_term  = '0;
    logic                  s_granted_in      = 1'b0;
    logic [TAG_W-1:0]      s_request_tag     = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic [1:0]            m_kind;
    logic [ID_W-1:0]       m_dest;
    logic [TERM_W-1:0]     m_out_term;
    logic                  m_granted_out;
    logic [LOG_W-1:0]      m_out_last_index;
    logic [TERM_W-1:0]     m_out_last_term;
    logic [TAG_W-1:0]      m_tag_out;
    logic [1:0]            m_role_now;
    logic                  m_last;

    election_scoreboard sb = new();

    int          burst_left  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_mode  = 0;
    int unsigned idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    raft_leader_election_unit i_dut (.*);

    // Result side: check every transfer, then pick m_ready for the next cycle.
    // Stall modes: always ready, mostly ready, mostly stalled; each held for a while.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(result_t'{m_kind, m_dest, m_out_term, m_granted_out,
                                      m_out_last_index, m_out_last_term, m_tag_out,
                                      m_role_now, m_last});
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("raft_leader_election_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic item_t mk(op_t op, logic [ID_W-1:0] peer, logic [TERM_W-1:0] mterm,
                                 logic [LOG_W-1:0] li, logic [TERM_W-1:0] lt, logic g,
                                 logic [TAG_W-1:0] tag);
        item_t it;
        it.op              = op;
        it.peer_id         = peer;
        it.msg_term        = mterm;
        it.cand_last_index = li;
        it.cand_last_term  = lt;
        it.granted_in      = g;
        it.request_tag     = tag;
        return it;
    endfunction

    function automatic logic [TERM_W-1:0] near_term(logic [TERM_W-1:0] t);
        case ($urandom_range(0, 5))
            0:       return t - 1;
            1, 2:    return t + 1;
            default: return t;
        endcase
    endfunction

    // Mostly messages that fit the node's current role and term, so elections get
    // won and lost; a slice of unused op codes and wild terms as noise.
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick, roll;
        it.op              = OP_VREQ;
        it.peer_id         = ID_W'($urandom);
        it.msg_term        = $urandom;
        it.cand_last_index = $urandom;
        it.cand_last_term  = $urandom;
        it.granted_in      = 1'($urandom);
        it.request_tag     = TAG_W'($urandom);
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (pick < 4) begin
            it.op = OP_NONE;
        end else if (pick < 10) begin
            it.op = 2'($urandom_range(0, 2));
        end else begin
            case (sb.role)
                ROLE_CANDIDATE: it.op = (roll < 75) ? OP_VRESP : (roll < 90) ? OP_VREQ : OP_TICK;
                ROLE_LEADER:    it.op = (roll < 50) ? OP_VREQ : (roll < 75) ? OP_TICK : OP_VRESP;
                default:        it.op = (roll < 45) ? OP_TICK : (roll < 85) ? OP_VREQ : OP_VRESP;
            endcase
            it.msg_term = near_term(sb.term);
            if (it.op == OP_VRESP && sb.role == ROLE_CANDIDATE && $urandom_range(0, 3) != 0) begin
                it.msg_term   = sb.term;
                it.granted_in = ($urandom_range(0, 4) != 0);
            end
            if (it.op == OP_VREQ) begin
                // a few repeat candidates so a second request from the same peer shows up
                if ($urandom_range(0, 1)) it.peer_id = ID_W'($urandom_range(0, 3));
                if ($urandom_range(0, 3) != 0) begin
                    it.cand_last_term  = sb.own_last_term + 32'($urandom_range(0, 2)) - 32'd1;
                    it.cand_last_index = sb.own_last_index + 32'($urandom_range(0, 2)) - 32'd1;
                end
            end
        end
        return it;
    endfunction

    // Input side: bursts of back-to-back transfers separated by random gaps.
    task automatic send(input item_t it);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(1, 6);
        end
        s_op              <= it.op;
        s_peer_id         <= it.peer_id;
        s_msg_term        <= it.msg_term;
        s_cand_last_index <= it.cand_last_index;
        s_cand_last_term  <= it.cand_last_term;
        s_granted_in      <= it.granted_in;
        s_request_tag     <= it.request_tag;
        s_valid           <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        burst_left--;
    endtask

    // Leaves cfg_we high so back-to-back writes need one assignment per edge.
    task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [31:0] node, logic [31:0] size,
                             logic [31:0] li, logic [31:0] lt);
        set_reg(REG_NODE_ID, node);
        set_reg(REG_CLUSTER, size);
        set_reg(REG_LAST_IDX, li);
        set_reg(REG_LAST_TRM, lt);
        cfg_we <= 1'b0;
    endtask

    // Quiesce: all results back, then a margin for a tick that produced nothing.
    task automatic settle();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_random(int unsigned count);
        repeat (count) send(random_item());
    endtask

    // One cluster setup: force a fresh election, then random traffic.
    task automatic phase(logic [31:0] node, logic [31:0] size,
                         logic [31:0] li, logic [31:0] lt);
        configure(node, size, li, lt);
        if (sb.role == ROLE_LEADER)
            send(mk(OP_VREQ, 4'd0, sb.term + 1, '0, '0, 1'b0, 16'h0));
        send(mk(OP_TICK, 4'd0, '0, '0, '0, 1'b0, 16'h0));
        run_random(16);
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: node 0 in a cluster of three, empty log.
        send(mk(OP_NONE,  4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
        send(mk(OP_VRESP, 4'd1, 32'd0, '0, '0, 1'b1, 16'h0));       // follower ignores
        send(mk(OP_VREQ,  4'd5, 32'd0, '0, '0, 1'b0, 16'hFFFF));    // first vote of term 0
        send(mk(OP_VREQ,  4'd6, 32'd0, '0, '0, 1'b0, 16'h1234));    // already voted
        send(mk(OP_VREQ,  4'd5, 32'd0, '0, '0, 1'b0, 16'h0001));    // same peer again
        send(mk(OP_TICK,  4'd0, '0, '0, '0, 1'b0, 16'h0));          // election, term 1
        send(mk(OP_VRESP, 4'd1, 32'd0, '0, '0, 1'b1, 16'h0));       // stale term
        send(mk(OP_VRESP, 4'd1, 32'd1, '0, '0, 1'b0, 16'h0));       // refused vote
        send(mk(OP_VRESP, 4'd1, 32'd1, '0, '0, 1'b1, 16'h0));       // majority
        send(mk(OP_TICK,  4'd0, '0, '0, '0, 1'b0, 16'h0));          // leader ignores tick
        send(mk(OP_VREQ,  4'd2, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'h00AA));
        send(mk(OP_VREQ,  4'd3, 32'd0, '0, '0, 1'b0, 16'h0055));    // lower term refused
        send(mk(OP_VREQ,  4'd4, 32'd7, '0, '0, 1'b0, 16'h0F0F));    // step down to term 7
        send(mk(OP_TICK,  4'd0, '0, '0, '0, 1'b0, 16'h0));
        send(mk(OP_VRESP, 4'd2, 32'd9, '0, '0, 1'b1, 16'h0));       // newer term: step down
        send(mk(OP_VREQ,  4'd1, 32'hFFFF_FFFF, '0, '0, 1'b0, 16'hF0F0));
        send(mk(OP_TICK,  4'd0, '0, '0, '0, 1'b0, 16'h0));          // term wraps to zero
        send(mk(OP_VRESP, 4'd2, 32'd0, '0, '0, 1'b1, 16'h0));
        settle();

        // Log freshness rules against index 100, term 7.
        configure(32'd2, 32'd5, 32'd100, 32'd7);
        send(mk(OP_VREQ, 4'd1, 32'd1, 32'd1000, 32'd6, 1'b0, 16'h0101));  // older log term
        send(mk(OP_VREQ, 4'd1, 32'd1, 32'd99, 32'd7, 1'b0, 16'h0202));    // shorter log
        send(mk(OP_VREQ, 4'd1, 32'd1, 32'd100, 32'd7, 1'b0, 16'h0303));   // equal log
        send(mk(OP_VREQ, 4'd3, 32'd2, 32'd0, 32'd8, 1'b0, 16'h0404));     // newer log term
        run_random(22);
        settle();

        phase(32'd0,  32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // widest fan-out, log at top
        phase(32'd0,  32'd1,  32'd0,         32'd0);          // single node, no requests
        phase(32'd7,  32'd0,  32'h0000_0010, 32'h8000_0000);  // size zero, node outside
        phase(32'd9,  32'd31, 32'h1234_5678, 32'd3);          // oversize cluster clamps
        phase(32'd15, 32'd3,  32'd50,        32'd2);          // node id beyond the cluster
        phase(32'd1,  32'd2,  32'd5,         32'd3);

        if (sb.pending() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
        $display("covered %0d input transfers over 8 cluster setups, %0d results checked",
                 sb.items, sb.results);
        $display("  %0d vote requests, %0d vote replies, %0d elections won, %0d mismatches",
                 sb.requests, sb.replies, sb.notices, sb.errors);
        if (sb.errors == 0) begin
            $display("raft_leader_election_unit regression: pass");
        end else begin
            $display("raft_leader_election_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/rle_pkg.sv
design/rle_core.sv
design/rle_req_gen.sv
design/raft_leader_election_unit.sv
tb/testbench.sv
